// File: rtl/core/pbam_pkg.sv
// Shared types and constants for the paged bus address map.
// Used by every module of the block; depends on nothing.
package pbam_pkg;

	localparam int ADDR_BITS     = 16;
	localparam int PAGE_BITS     = 8;
	localparam int PAGE_NUM_BITS = ADDR_BITS - PAGE_BITS;
	localparam int NUM_PAGES     = 1 << PAGE_NUM_BITS;
	localparam int PAGE_SIZE     = 1 << PAGE_BITS;
	localparam int COUNT_BITS    = PAGE_BITS + 1;
	localparam int LEN_BITS      = 17;
	localparam int BACKING_BITS  = 24;
	localparam int DEVICE_BITS   = 4;
	localparam int TYPE_BITS     = 2;
	localparam int QUEUE_DEPTH   = 2;

	localparam int MAX_ACCESS_DEFAULT = 64;

	localparam logic [TYPE_BITS-1:0] REQ_MAP   = 2'd0;
	localparam logic [TYPE_BITS-1:0] REQ_READ  = 2'd1;
	localparam logic [TYPE_BITS-1:0] REQ_WRITE = 2'd2;

	typedef enum logic [2:0] {
		STATUS_OK       = 3'd0,
		STATUS_UNMAPPED = 3'd1,
		STATUS_RANGE    = 3'd2,
		STATUS_MAPPED   = 3'd3,
		STATUS_TOO_LONG = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_REPLY  = 2'd0,
		CMD_MAP    = 2'd1,
		CMD_ACCESS = 2'd2
	} cmd_kind_t;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		cmd_kind_t                  kind;
		status_t                    status;
		logic                       is_write;
		logic [ADDR_BITS-1:0]       address;
		logic [LEN_BITS-1:0]        length;
		logic [PAGE_NUM_BITS-1:0]   last_page;
		logic [BACKING_BITS-1:0]    backing_base;
		logic [DEVICE_BITS-1:0]     device_id;
	} cmd_t;

	// One page entry; the start is kept as its offset inside the page.
	typedef struct packed {
		logic [PAGE_BITS-1:0]    offset;
		logic [COUNT_BITS-1:0]   bytes;
		logic [BACKING_BITS-1:0] backing;
		logic [DEVICE_BITS-1:0]  device;
	} entry_t;

	// Handshake between the command queue and the back end.
	typedef struct packed {
		logic not_empty;
		logic pop;
	} queue_ctrl_t;

endpackage

// File: rtl/core/pbam_front.sv
// Front end: accepts request items and classifies them into commands.
// Depends on pbam_pkg; feeds pbam_cmd_queue.
module pbam_front #(
	parameter int MAX_ACCESS = pbam_pkg::MAX_ACCESS_DEFAULT
) (
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pbam_pkg::TYPE_BITS-1:0]       req_type,
	input  logic [pbam_pkg::ADDR_BITS-1:0]       address,
	input  logic [pbam_pkg::LEN_BITS-1:0]        length,
	input  logic [pbam_pkg::BACKING_BITS-1:0]    backing_base,
	input  logic [pbam_pkg::DEVICE_BITS-1:0]     device_id,
	input  logic                                 queue_full,
	output logic                                 push,
	output pbam_pkg::cmd_t                       cmd
);

	localparam int END_BITS = pbam_pkg::LEN_BITS + 1;

	logic [END_BITS-1:0] region_end;
	logic                past_top;
	logic                len_zero;
	logic                too_long;
	logic                known;

	assign region_end = END_BITS'(address) + END_BITS'(length) - END_BITS'(1);
	assign past_top   = region_end[END_BITS-1:pbam_pkg::ADDR_BITS] != '0;
	assign len_zero   = length == '0;
	assign too_long   = length > pbam_pkg::LEN_BITS'(MAX_ACCESS);
	assign known      = (req_type == pbam_pkg::REQ_MAP) || (req_type == pbam_pkg::REQ_READ)
		|| (req_type == pbam_pkg::REQ_WRITE);

	assign in_stall = queue_full;
	// Items of an unknown type are taken and dropped without a result.
	assign push = in_valid && !queue_full && known;

	always_comb begin
		cmd.kind         = pbam_pkg::CMD_REPLY;
		cmd.status       = pbam_pkg::STATUS_OK;
		cmd.is_write     = req_type == pbam_pkg::REQ_WRITE;
		cmd.address      = address;
		cmd.length       = length;
		cmd.last_page    = region_end[pbam_pkg::ADDR_BITS-1:pbam_pkg::PAGE_BITS];
		cmd.backing_base = backing_base;
		cmd.device_id    = device_id;
		if (req_type == pbam_pkg::REQ_MAP) begin
			if (len_zero) begin
				cmd.kind = pbam_pkg::CMD_REPLY;
			end else if (past_top) begin
				cmd.status = pbam_pkg::STATUS_RANGE;
			end else begin
				cmd.kind = pbam_pkg::CMD_MAP;
			end
		end else begin
			if (too_long) begin
				cmd.status = pbam_pkg::STATUS_TOO_LONG;
			end else if (!len_zero) begin
				cmd.kind = pbam_pkg::CMD_ACCESS;
			end
		end
	end

endmodule

// File: rtl/core/pbam_cmd_queue.sv
// Short command queue between the front and the back end.
// Depends on pbam_pkg for the command type and depth.
module pbam_cmd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pbam_pkg::cmd_t        cmd_in,
	output logic                  full,
	input  pbam_pkg::queue_ctrl_t ctrl_in,
	output logic                  not_empty,
	output pbam_pkg::cmd_t        cmd_out
);

	localparam int DEPTH     = pbam_pkg::QUEUE_DEPTH;
	localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	pbam_pkg::cmd_t      slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_pop;

	assign full      = count_q == CNT_BITS'(DEPTH);
	assign not_empty = count_q != '0;
	assign cmd_out   = slot_q[rd_ptr_q];
	assign do_pop    = ctrl_in.pop && ctrl_in.not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

// File: rtl/core/pbam_back.sv
// Back end: holds the page table, walks map requests, splits accesses into
// chunks and drives the result register. Depends on pbam_pkg.
module pbam_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	input  pbam_pkg::cmd_t                       cmd,
	output pbam_pkg::queue_ctrl_t                ctrl,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [2:0]                           status,
	output logic [pbam_pkg::BACKING_BITS-1:0]    backing_address,
	output logic [pbam_pkg::COUNT_BITS-1:0]      chunk_bytes,
	output logic [pbam_pkg::DEVICE_BITS-1:0]     owner_device,
	output logic [pbam_pkg::ADDR_BITS-1:0]       fault_address,
	output logic                                 is_write,
	output logic                                 last
);

	localparam int AB  = pbam_pkg::ADDR_BITS;
	localparam int PB  = pbam_pkg::PAGE_BITS;
	localparam int PNB = pbam_pkg::PAGE_NUM_BITS;
	localparam int CB  = pbam_pkg::COUNT_BITS;
	localparam int LB  = pbam_pkg::LEN_BITS;
	localparam int BB  = pbam_pkg::BACKING_BITS;
	localparam int DB  = pbam_pkg::DEVICE_BITS;

	typedef enum logic [4:0] {
		S_IDLE      = 5'b00001,
		S_MAP_CHECK = 5'b00010,
		S_MAP_WRITE = 5'b00100,
		S_MAP_DONE  = 5'b01000,
		S_ACC_EVAL  = 5'b10000
	} state_t;

	state_t               state_q;
	state_t               state_d;

	pbam_pkg::entry_t     entry_mem_q [pbam_pkg::NUM_PAGES];
	logic [pbam_pkg::NUM_PAGES-1:0] valid_q;
	pbam_pkg::entry_t     entry_rd_q;
	logic                 entry_rd_valid_q;

	logic [PNB-1:0]       page_q;
	logic [PNB-1:0]       last_page_q;
	logic [AB-1:0]        cur_q;
	logic [LB-1:0]        rem_q;
	logic [BB-1:0]        bk_q;
	logic [DB-1:0]        dev_q;
	logic                 wr_q;
	logic                 first_q;
	logic [AB-1:0]        addr0_q;
	pbam_pkg::status_t    status_q;

	logic                 out_valid_q;
	pbam_pkg::status_t    res_status_q;
	logic [BB-1:0]        res_backing_q;
	logic [CB-1:0]        res_bytes_q;
	logic [DB-1:0]        res_dev_q;
	logic [AB-1:0]        res_fault_q;
	logic                 res_wr_q;
	logic                 res_last_q;

	logic                 out_free;
	logic                 emit;
	pbam_pkg::status_t    e_status;
	logic [BB-1:0]        e_backing;
	logic [CB-1:0]        e_bytes;
	logic [DB-1:0]        e_dev;
	logic [AB-1:0]        e_fault;
	logic                 e_last;

	logic [PNB-1:0]       rd_page;
	logic                 mem_we;
	pbam_pkg::entry_t     mem_wdata;

	// Access chunk evaluation against the entry read for the current page.
	logic [AB-1:0]        ent_start;
	logic [LB-1:0]        ent_end;
	logic                 outside;
	logic [CB-1:0]        span;
	logic [CB-1:0]        chunk;
	logic                 finish;
	logic [AB-1:0]        next_cur;

	// Map page fill.
	logic [CB-1:0]        room;
	logic [CB-1:0]        fill;

	assign out_free = !out_valid_q || !out_stall;

	assign ent_start = {cur_q[AB-1:PB], entry_rd_q.offset};
	assign ent_end   = LB'(ent_start) + LB'(entry_rd_q.bytes);
	assign outside   = (cur_q < ent_start) || (LB'(cur_q) >= ent_end);
	assign span      = CB'(ent_end - LB'(cur_q));
	assign chunk     = (rem_q < LB'(span)) ? CB'(rem_q) : span;
	assign finish    = LB'(chunk) == rem_q;
	assign next_cur  = cur_q + AB'(chunk);

	assign room = CB'(pbam_pkg::PAGE_SIZE) - CB'(cur_q[PB-1:0]);
	assign fill = (rem_q < LB'(room)) ? CB'(rem_q) : room;

	always_comb begin
		state_d   = state_q;
		ctrl.pop  = 1'b0;
		ctrl.not_empty = cmd_valid;
		emit      = 1'b0;
		e_status  = pbam_pkg::STATUS_OK;
		e_backing = '0;
		e_bytes   = '0;
		e_dev     = '0;
		e_fault   = '0;
		e_last    = 1'b1;
		rd_page   = cur_q[AB-1:PB];
		mem_we    = 1'b0;
		mem_wdata.offset  = cur_q[PB-1:0];
		mem_wdata.bytes   = fill;
		mem_wdata.backing = bk_q;
		mem_wdata.device  = dev_q;
		unique case (state_q)
			S_IDLE: begin
				rd_page = cmd.address[AB-1:PB];
				if (cmd_valid) begin
					unique case (cmd.kind)
						pbam_pkg::CMD_REPLY: begin
							if (out_free) begin
								ctrl.pop = 1'b1;
								emit     = 1'b1;
								e_status = cmd.status;
								if (cmd.status == pbam_pkg::STATUS_TOO_LONG) begin
									e_fault = cmd.address;
								end
							end
						end
						pbam_pkg::CMD_MAP: begin
							ctrl.pop = 1'b1;
							state_d  = S_MAP_CHECK;
						end
						pbam_pkg::CMD_ACCESS: begin
							ctrl.pop = 1'b1;
							state_d  = S_ACC_EVAL;
						end
						default: begin
							ctrl.pop = 1'b1;
						end
					endcase
				end
			end
			S_MAP_CHECK: begin
				if (valid_q[page_q]) begin
					state_d = S_MAP_DONE;
				end else if (page_q == last_page_q) begin
					state_d = S_MAP_WRITE;
				end
			end
			S_MAP_WRITE: begin
				mem_we = 1'b1;
				if (page_q == last_page_q) begin
					state_d = S_MAP_DONE;
				end
			end
			S_MAP_DONE: begin
				if (out_free) begin
					emit     = 1'b1;
					e_status = status_q;
					state_d  = S_IDLE;
				end
			end
			S_ACC_EVAL: begin
				if (out_free) begin
					emit = 1'b1;
					if (!entry_rd_valid_q) begin
						e_status = pbam_pkg::STATUS_UNMAPPED;
						e_fault  = addr0_q;
					end else if (outside) begin
						e_status = pbam_pkg::STATUS_RANGE;
						e_dev    = entry_rd_q.device;
						e_fault  = cur_q;
					end else if (!first_q && !finish) begin
						// Only two results per access: a second chunk that would not
						// finish it reports where it stopped.
						e_status = pbam_pkg::STATUS_RANGE;
						e_dev    = entry_rd_q.device;
						e_fault  = next_cur;
					end else begin
						e_backing = entry_rd_q.backing
							+ BB'(cur_q[PB-1:0] - entry_rd_q.offset);
						e_bytes   = chunk;
						e_dev     = entry_rd_q.device;
						e_last    = finish;
					end
					if (e_last) begin
						state_d = S_IDLE;
					end else begin
						rd_page = next_cur[AB-1:PB];
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				valid_q[page_q] <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Page table storage with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[page_q] <= mem_wdata;
		end
		entry_rd_q       <= entry_mem_q[rd_page];
		entry_rd_valid_q <= valid_q[rd_page];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_status_q  <= e_status;
			res_backing_q <= e_backing;
			res_bytes_q   <= e_bytes;
			res_dev_q     <= e_dev;
			res_fault_q   <= e_fault;
			res_wr_q      <= (state_q == S_IDLE) ? cmd.is_write :
				((state_q == S_ACC_EVAL) ? wr_q : 1'b0);
			res_last_q    <= e_last;
		end
		unique case (state_q)
			S_IDLE: begin
				page_q      <= cmd.address[AB-1:PB];
				last_page_q <= cmd.last_page;
				cur_q       <= cmd.address;
				addr0_q     <= cmd.address;
				rem_q       <= cmd.length;
				bk_q        <= cmd.backing_base;
				dev_q       <= cmd.device_id;
				wr_q        <= cmd.is_write;
				first_q     <= 1'b1;
				status_q    <= pbam_pkg::STATUS_OK;
			end
			S_MAP_CHECK: begin
				if (valid_q[page_q]) begin
					status_q <= pbam_pkg::STATUS_MAPPED;
				end else if (page_q == last_page_q) begin
					page_q <= cur_q[AB-1:PB];
				end else begin
					page_q <= page_q + PNB'(1);
				end
			end
			S_MAP_WRITE: begin
				cur_q  <= cur_q + AB'(fill);
				rem_q  <= rem_q - LB'(fill);
				bk_q   <= bk_q + BB'(fill);
				page_q <= page_q + PNB'(1);
			end
			S_MAP_DONE: begin
				status_q <= status_q;
			end
			S_ACC_EVAL: begin
				if (emit && !e_last) begin
					cur_q   <= next_cur;
					rem_q   <= rem_q - LB'(chunk);
					first_q <= 1'b0;
				end
			end
			default: begin
				first_q <= first_q;
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign status          = res_status_q;
	assign backing_address = res_backing_q;
	assign chunk_bytes     = res_bytes_q;
	assign owner_device    = res_dev_q;
	assign fault_address   = res_fault_q;
	assign is_write        = res_wr_q;
	assign last            = res_last_q;

endmodule

// File: rtl/core/paged_bus_address_map_core.sv
// Paged bus address map: a 256-entry page decode table for a 16-bit bus with
// 256-byte pages. Map requests claim a region page by page; read and write
// accesses are split at entry boundaries into at most two result items. An
// access reads the page table through its registered read port before its
// result is formed, and reads it again for a second chunk. A refused or
// zero-length request gives its result in the cycle after it leaves the
// queue. A map request checks one page per cycle and then, if none is in
// use, writes one page per cycle. A two-deep command queue lets new items
// be taken while the back end is busy, and a result register holds a
// finished result until it is taken.
// Depends on pbam_pkg, pbam_front, pbam_cmd_queue and pbam_back.
module paged_bus_address_map_core #(
	parameter int MAX_ACCESS = pbam_pkg::MAX_ACCESS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pbam_pkg::TYPE_BITS-1:0]       req_type,
	input  logic [pbam_pkg::ADDR_BITS-1:0]       address,
	input  logic [pbam_pkg::LEN_BITS-1:0]        length,
	input  logic [pbam_pkg::BACKING_BITS-1:0]    backing_base,
	input  logic [pbam_pkg::DEVICE_BITS-1:0]     device_id,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [2:0]                           status,
	output logic [pbam_pkg::BACKING_BITS-1:0]    backing_address,
	output logic [pbam_pkg::COUNT_BITS-1:0]      chunk_bytes,
	output logic [pbam_pkg::DEVICE_BITS-1:0]     owner_device,
	output logic [pbam_pkg::ADDR_BITS-1:0]       fault_address,
	output logic                                 is_write,
	output logic                                 last
);

	logic                  queue_full;
	logic                  push;
	pbam_pkg::cmd_t        front_cmd;
	pbam_pkg::cmd_t        queue_cmd;
	logic                  queue_not_empty;
	pbam_pkg::queue_ctrl_t back_ctrl;

	pbam_front #(
		.MAX_ACCESS(MAX_ACCESS)
	) u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.address      (address),
		.length       (length),
		.backing_base (backing_base),
		.device_id    (device_id),
		.queue_full   (queue_full),
		.push         (push),
		.cmd          (front_cmd)
	);

	pbam_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd_in    (front_cmd),
		.full      (queue_full),
		.ctrl_in   (back_ctrl),
		.not_empty (queue_not_empty),
		.cmd_out   (queue_cmd)
	);

	pbam_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (queue_not_empty),
		.cmd             (queue_cmd),
		.ctrl            (back_ctrl),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.backing_address (backing_address),
		.chunk_bytes     (chunk_bytes),
		.owner_device    (owner_device),
		.fault_address   (fault_address),
		.is_write        (is_write),
		.last            (last)
	);

endmodule

// File: tb/pbam_checker.sv
// Scoreboard for the paged bus address map: keeps its own copy of the page table,
// predicts the result items of every request taken in and compares the items sent out.
// Depends on pbam_pkg; instantiated by testbench beside the block.
`timescale 1ns / 100ps

module pbam_checker #(
	parameter int MAX_ACCESS = pbam_pkg::MAX_ACCESS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [pbam_pkg::TYPE_BITS-1:0]       req_type,
	input  logic [pbam_pkg::ADDR_BITS-1:0]       address,
	input  logic [pbam_pkg::LEN_BITS-1:0]        length,
	input  logic [pbam_pkg::BACKING_BITS-1:0]    backing_base,
	input  logic [pbam_pkg::DEVICE_BITS-1:0]     device_id,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [2:0]                           status,
	input  logic [pbam_pkg::BACKING_BITS-1:0]    backing_address,
	input  logic [pbam_pkg::COUNT_BITS-1:0]      chunk_bytes,
	input  logic [pbam_pkg::DEVICE_BITS-1:0]     owner_device,
	input  logic [pbam_pkg::ADDR_BITS-1:0]       fault_address,
	input  logic                                 is_write,
	input  logic                                 last,
	output int                                   fail_count,
	output int                                   pending_results
);
	import pbam_pkg::*;

	localparam int ADDR_MASK = (1 << ADDR_BITS) - 1;
	localparam int PAGE_MASK = PAGE_SIZE - 1;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		status_t                  status;
		logic [BACKING_BITS-1:0]  backing;
		logic [COUNT_BITS-1:0]    bytes;
		logic [DEVICE_BITS-1:0]   device;
		logic [ADDR_BITS-1:0]     fault;
		logic                     wr;
		logic                     last;
	} chunk_result_t;

	// Shadow page table.
	bit                      page_used[NUM_PAGES];
	logic [ADDR_BITS-1:0]    page_start[NUM_PAGES];
	logic [COUNT_BITS-1:0]   page_bytes[NUM_PAGES];
	logic [BACKING_BITS-1:0] page_backing[NUM_PAGES];
	logic [DEVICE_BITS-1:0]  page_device[NUM_PAGES];

	chunk_result_t expected_chunks[$];
	int mismatches = 0;

	initial begin
		fail_count = 0;
		pending_results = 0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic void push_chunk(status_t st, logic [BACKING_BITS-1:0] bk, int nb,
			logic [DEVICE_BITS-1:0] dev, int fault, logic wr, logic fin);
		chunk_result_t r;
		r.status  = st;
		r.backing = bk;
		r.bytes   = nb[COUNT_BITS-1:0];
		r.device  = dev;
		r.fault   = fault[ADDR_BITS-1:0];
		r.wr      = wr;
		r.last    = fin;
		expected_chunks.push_back(r);
	endfunction

	function automatic void claim_region(int base_addr, int size,
			logic [BACKING_BITS-1:0] backing, logic [DEVICE_BITS-1:0] dev);
		int first_page, last_page, cur, rem, n;
		logic [BACKING_BITS-1:0] bk;
		if (size == 0) begin
			push_chunk(STATUS_OK, '0, 0, '0, 0, 1'b0, 1'b1);
			return;
		end
		if (base_addr + size - 1 > ADDR_MASK) begin
			push_chunk(STATUS_RANGE, '0, 0, '0, 0, 1'b0, 1'b1);
			return;
		end
		first_page = base_addr >> PAGE_BITS;
		last_page  = (base_addr + size - 1) >> PAGE_BITS;
		for (int p = first_page; p <= last_page; p++) begin
			if (page_used[p]) begin
				push_chunk(STATUS_MAPPED, '0, 0, '0, 0, 1'b0, 1'b1);
				return;
			end
		end
		// The first page covers only the bytes from the region start to its end.
		cur = base_addr;
		rem = size;
		bk  = backing;
		for (int p = first_page; p <= last_page; p++) begin
			n = PAGE_SIZE - (cur & PAGE_MASK);
			if (rem < n)
				n = rem;
			page_used[p]    = 1'b1;
			page_start[p]   = cur[ADDR_BITS-1:0];
			page_bytes[p]   = n[COUNT_BITS-1:0];
			page_backing[p] = bk;
			page_device[p]  = dev;
			cur += n;
			rem -= n;
			bk  += n[BACKING_BITS-1:0];
		end
		push_chunk(STATUS_OK, '0, 0, '0, 0, 1'b0, 1'b1);
	endfunction

	function automatic void split_access(int first_addr, int size, logic wr);
		int done, chunks, cur, p, st, fin, n;
		logic [BACKING_BITS-1:0] bk;
		if (size > MAX_ACCESS) begin
			push_chunk(STATUS_TOO_LONG, '0, 0, '0, first_addr, wr, 1'b1);
			return;
		end
		if (size == 0) begin
			push_chunk(STATUS_OK, '0, 0, '0, 0, wr, 1'b1);
			return;
		end
		done = 0;
		chunks = 0;
		while (done < size) begin
			cur = (first_addr + done) & ADDR_MASK;
			p = cur >> PAGE_BITS;
			if (!page_used[p]) begin
				push_chunk(STATUS_UNMAPPED, '0, 0, '0, first_addr, wr, 1'b1);
				return;
			end
			st  = page_start[p];
			fin = st + page_bytes[p];
			if (cur < st || cur >= fin) begin
				push_chunk(STATUS_RANGE, '0, 0, page_device[p], cur, wr, 1'b1);
				return;
			end
			n = fin - cur;
			if (size - done < n)
				n = size - done;
			// Only two items per access: a second chunk that does not finish it
			// turns into a range error at the address reached.
			if (chunks == 1 && done + n < size) begin
				push_chunk(STATUS_RANGE, '0, 0, page_device[p], (cur + n) & ADDR_MASK, wr,
					1'b1);
				return;
			end
			bk = page_backing[p] + BACKING_BITS'(cur - st);
			push_chunk(STATUS_OK, bk, n, page_device[p], 0, wr, done + n >= size);
			done += n;
			chunks++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		chunk_result_t want;
		if (!arst_n) begin
			foreach (page_used[p])
				page_used[p] = 1'b0;
			expected_chunks.delete();
			pending_results <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_chunks.size() == 0) begin
					report_mismatch("result item with nothing expected");
				end else begin
					want = expected_chunks.pop_front();
					check_field("status", status, want.status);
					check_field("backing_address", backing_address, want.backing);
					check_field("chunk_bytes", chunk_bytes, want.bytes);
					check_field("owner_device", owner_device, want.device);
					check_field("fault_address", fault_address, want.fault);
					check_field("is_write", is_write, want.wr);
					check_field("last", last, want.last);
				end
			end
			if (in_valid && !in_stall) begin
				case (req_type)
					REQ_MAP:   claim_region(address, length, backing_base, device_id);
					REQ_READ:  split_access(address, length, 1'b0);
					REQ_WRITE: split_access(address, length, 1'b1);
					default:   ;
				endcase
			end
			pending_results <= expected_chunks.size();
			fail_count <= mismatches;
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the paged bus address map testbench: clock, reset, request stimulus,
// receiver stalls, watchdog and verdict. Depends on pbam_pkg,
// paged_bus_address_map_core and pbam_checker.
`timescale 1ns / 100ps

module testbench;
	import pbam_pkg::*;

	localparam logic [TYPE_BITS-1:0] REQ_UNKNOWN = 2'd3;
	localparam int RANDOM_REQUESTS = 680;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [TYPE_BITS-1:0]    req_type;
	logic [ADDR_BITS-1:0]    address;
	logic [LEN_BITS-1:0]     length;
	logic [BACKING_BITS-1:0] backing_base;
	logic [DEVICE_BITS-1:0]  device_id;
	logic                    out_valid;
	logic                    out_stall;
	logic [2:0]              status;
	logic [BACKING_BITS-1:0] backing_address;
	logic [COUNT_BITS-1:0]   chunk_bytes;
	logic [DEVICE_BITS-1:0]  owner_device;
	logic [ADDR_BITS-1:0]    fault_address;
	logic                    is_write;
	logic                    last;
	int                      fail_count;
	int                      pending_results;

	int burst_left = 0;
	int region_base[$];
	int region_size[$];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	paged_bus_address_map_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .address(address), .length(length),
		.backing_base(backing_base), .device_id(device_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .backing_address(backing_address), .chunk_bytes(chunk_bytes),
		.owner_device(owner_device), .fault_address(fault_address),
		.is_write(is_write), .last(last)
	);

	pbam_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .address(address), .length(length),
		.backing_base(backing_base), .device_id(device_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .backing_address(backing_address), .chunk_bytes(chunk_bytes),
		.owner_device(owner_device), .fault_address(fault_address),
		.is_write(is_write), .last(last),
		.fail_count(fail_count), .pending_results(pending_results)
	);

	// Offers one item and returns at the edge that takes it. Between bursts the
	// valid line may drop for a random gap.
	task automatic send_request(input logic [TYPE_BITS-1:0] kind, input int addr,
			input int size, input int backing, input int dev);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid     <= 1'b1;
		req_type     <= kind;
		address      <= addr[ADDR_BITS-1:0];
		length       <= size[LEN_BITS-1:0];
		backing_base <= backing[BACKING_BITS-1:0];
		device_id    <= dev[DEVICE_BITS-1:0];
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		burst_left--;
	endtask

	initial begin : receiver
		int mode, span;
		out_stall <= 1'b0;
		repeat (600) begin
			@(posedge clk);
			out_stall <= ($urandom_range(0, 2) == 0);
		end
		// Long hold-off so the queue fills and the input side backs up.
		@(posedge clk);
		out_stall <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 150);
			repeat (span) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= 1'($urandom_range(0, 1));
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin : stimulus
		int pick, idx, addr, size, taken;
		logic [TYPE_BITS-1:0] kind;
		in_valid     <= 1'b0;
		req_type     <= REQ_MAP;
		address      <= '0;
		length       <= '0;
		backing_base <= '0;
		device_id    <= '0;
		arst_n       <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed part: empty table, region edges, wrap, refusals, ignored type.
		send_request(REQ_READ,    16'h1234, 4,      0,          0);
		send_request(REQ_MAP,     16'hFF00, 256,    'hFFFFF0,   15);
		send_request(REQ_MAP,     16'h0000, 1,      0,          0);
		send_request(REQ_MAP,     16'h0000, 0,      'h555555,   3);
		send_request(REQ_MAP,     16'hFFFF, 2,      'h111111,   1);
		send_request(REQ_MAP,     16'h0000, 131071, 'hABCDEF,   2);
		send_request(REQ_MAP,     16'h1080, 'h180,  'h123456,   5);
		send_request(REQ_MAP,     16'h1100, 16,     'h000100,   6);
		send_request(REQ_WRITE,   16'h10F0, 32,     0,          0);
		send_request(REQ_READ,    16'h1000, 8,      0,          0);
		send_request(REQ_READ,    16'hFFF0, 32,     0,          0);
		send_request(REQ_WRITE,   16'h4000, 65,     0,          0);
		send_request(REQ_READ,    16'h4000, 65536,  0,          0);
		send_request(REQ_WRITE,   16'h2000, 0,      0,          0);
		send_request(REQ_READ,    16'h10FF, 64,     0,          0);
		send_request(REQ_UNKNOWN, 16'hFFFF, 131071, 'hFFFFFF,   15);
		send_request(REQ_READ,    16'hFFC0, 64,     0,          0);
		send_request(REQ_MAP,     16'h3000, 65536,  0,          7);
		send_request(REQ_MAP,     16'h0000, 65536,  0,          8);
		send_request(REQ_WRITE,   16'h0000, 1,      0,          0);
		send_request(REQ_READ,    16'h11F0, 32,     0,          0);
		send_request(REQ_MAP,     16'h2000, 256,    0,          9);
		send_request(REQ_WRITE,   16'h20C1, 63,     0,          0);

		// Random part: mostly accesses aimed at regions that were requested.
		taken = 0;
		while (taken < RANDOM_REQUESTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				addr = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 255) << PAGE_BITS)
					: $urandom_range(0, 65535);
				size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1200)
					: $urandom_range(1, 300);
				if (addr + size - 1 < (1 << ADDR_BITS)) begin
					region_base.push_back(addr);
					region_size.push_back(size);
				end
				send_request(REQ_MAP, addr, size, $urandom_range(0, 'hFFFFFF),
					$urandom_range(0, 15));
				taken++;
			end else if (pick < 85 && region_base.size() > 0) begin
				idx = $urandom_range(0, region_base.size() - 1);
				if ($urandom_range(0, 4) == 0)
					addr = region_base[idx] + region_size[idx] - $urandom_range(1, 8);
				else
					addr = region_base[idx] + $urandom_range(0, region_size[idx] - 1);
				size = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) * MAX_ACCESS_DEFAULT
					: $urandom_range(1, MAX_ACCESS_DEFAULT);
				kind = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
				send_request(kind, addr & 'hFFFF, size, $urandom_range(0, 'hFFFFFF),
					$urandom_range(0, 15));
				taken++;
			end else if (pick < 95) begin
				kind = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
				send_request(kind, $urandom_range(0, 65535), $urandom_range(0, 80),
					$urandom_range(0, 'hFFFFFF), $urandom_range(0, 15));
				taken++;
			end else begin
				// Noise: any type, oversized lengths.
				kind = TYPE_BITS'($urandom_range(0, 3));
				send_request(kind, $urandom_range(0, 65535), $urandom_range(65536, 131071),
					$urandom_range(0, 'hFFFFFF), $urandom_range(0, 15));
				if (kind != REQ_UNKNOWN)
					taken++;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
